### src/b64e_pkg.sv
// Package for the base64 stream encoder.
// Holds transaction payload types, the job record passed front to back,
// queue sizing and the alphabet mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned JobChars   = 4;
  localparam int unsigned JobIdxW    = $clog2(JobChars);

  localparam logic [6:0] PadChar   = 7'h3d;
  localparam logic [6:0] PlusChar  = 7'h2b;
  localparam logic [6:0] SlashChar = 7'h2f;
  localparam logic [6:0] UpperBase = 7'h41;
  localparam logic [6:0] LowerOff  = 7'h47;
  localparam logic [6:0] DigitOff  = 7'h7c;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic [JobChars-1:0][6:0] chars;
    logic [JobIdxW-1:0]       last_idx;
    logic                     fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_sts_t;

  function automatic logic [6:0] enc(input logic [5:0] six);
    logic [6:0] s;
    s = {1'b0, six};
    if (six < 6'd26) begin
      return UpperBase + s;
    end else if (six < 6'd52) begin
      return LowerOff + s;
    end else if (six < 6'd62) begin
      return DigitOff + s;
    end else if (six == 6'd62) begin
      return PlusChar;
    end else begin
      return SlashChar;
    end
  endfunction

endpackage

`default_nettype wire

### src/b64e_front.sv
// Front end of the base64 stream encoder: accepts bytes, tracks group phase
// and carried bits, and builds a character job per byte.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire b64e_pkg::in_t   in_i,
  input  wire b64e_pkg::q_sts_t q_sts_i,
  output logic                 push_o,
  output b64e_pkg::job_t       job_o
);

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhSecond = 2'd1,
    PhThird  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;

  assign b          = in_i.data_byte;
  assign in_stall_o = q_sts_i.full;
  assign push_o     = in_valid_i && !q_sts_i.full;

  always_comb begin
    job_o    = '0;
    phase_d  = PhStart;
    carry_d  = '0;
    case (phase_q)
      PhSecond: begin
        job_o.chars[0] = b64e_pkg::enc({carry_q[1:0], b[7:4]});
        if (in_i.last_byte) begin
          job_o.chars[1]  = b64e_pkg::enc({b[3:0], 2'b00});
          job_o.chars[2]  = b64e_pkg::PadChar;
          job_o.last_idx  = 2'd2;
          job_o.fin       = 1'b1;
        end else begin
          phase_d = PhThird;
          carry_d = b[3:0];
        end
      end
      PhThird: begin
        job_o.chars[0] = b64e_pkg::enc({carry_q, b[7:6]});
        job_o.chars[1] = b64e_pkg::enc(b[5:0]);
        job_o.last_idx = 2'd1;
        job_o.fin      = in_i.last_byte;
      end
      default: begin
        job_o.chars[0] = b64e_pkg::enc(b[7:2]);
        if (in_i.last_byte) begin
          job_o.chars[1] = b64e_pkg::enc({b[1:0], 4'b0000});
          job_o.chars[2] = b64e_pkg::PadChar;
          job_o.chars[3] = b64e_pkg::PadChar;
          job_o.last_idx = 2'd3;
          job_o.fin      = 1'b1;
        end else begin
          phase_d = PhSecond;
          carry_d = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      carry_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

### src/b64e_queue.sv
// Short job queue between the front and back of the base64 encoder.
// Register-based, one write and one read port. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire b64e_pkg::job_t   job_i,
  input  wire logic             pop_i,
  output b64e_pkg::job_t        job_o,
  output b64e_pkg::q_sts_t      sts_o
);

  b64e_pkg::job_t                  mem_q [b64e_pkg::QueueDepth];
  logic [b64e_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [b64e_pkg::QCntW-1:0]      cnt_q;

  function automatic logic [b64e_pkg::QPtrW-1:0] nxt(input logic [b64e_pkg::QPtrW-1:0] p);
    if (p == b64e_pkg::QPtrW'(b64e_pkg::QueueDepth - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  assign job_o       = mem_q[rd_q];
  assign sts_o.full  = (cnt_q == b64e_pkg::QCntW'(b64e_pkg::QueueDepth));
  assign sts_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/b64e_back.sv
// Back end of the base64 encoder: takes queued jobs and, while not stalled, emits
// one character per cycle through a registered output. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire b64e_pkg::job_t    job_i,
  input  wire b64e_pkg::q_sts_t  q_sts_i,
  output b64e_pkg::back_sts_t    sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output b64e_pkg::out_t         out_o
);

  b64e_pkg::job_t                cur_q;
  logic [b64e_pkg::JobIdxW-1:0]  idx_q;
  logic                          busy_q;
  logic                          out_valid_q;
  b64e_pkg::out_t                out_q;
  logic                          advance, emit, at_end, pop;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && busy_q;
  assign at_end  = (idx_q == cur_q.last_idx);
  assign pop     = !q_sts_i.empty && (!busy_q || (emit && at_end));

  assign sts_o.busy  = busy_q;
  assign sts_o.pop   = pop;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= job_i;
    end
    if (emit) begin
      out_q.out_char  <= cur_q.chars[idx_q];
      out_q.last_char <= cur_q.fin && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= busy_q;
      end
      if (pop) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        if (at_end) begin
          busy_q <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/base64_stream_encoder.sv
// Base64 stream encoder top level: one byte in, base64 characters out.
// Path: into an idle encoder, a byte's first character passes through the queue,
// the back end's job register and the output register before it is valid.
// Throughput: one byte per cycle in while the queue is not full; one character per
// cycle out while the output is not stalled, so three bytes in give four characters.
// Reset: asynchronous active low; clears group phase, carry, queue and output.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire b64e_pkg::in_t   in_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output b64e_pkg::out_t       out_o
);

  b64e_pkg::job_t      push_job, pop_job;
  b64e_pkg::q_sts_t    q_sts;
  b64e_pkg::back_sts_t back_sts;
  logic                push;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_sts_i    (q_sts),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (back_sts.pop),
    .job_o  (pop_job),
    .sts_o  (q_sts)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .q_sts_i     (q_sts),
    .sts_o       (back_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.pop |-> !q_sts.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_sts.full)
    else $error("queue pushed while full");

  a_idle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_sts.empty && !back_sts.busy) |-> ##3 out_valid_o)
    else $error("character missing after transaction into idle encoder");

endmodule

`default_nettype wire
